/* sv/snfcs_pkg.sv */
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer package
// Shared types, codes and constants for the sequencer front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
package snfcs_pkg;

   localparam int unsigned PAGE_SIZE_DEFAULT = 256;
   localparam int unsigned QUEUE_DEPTH       = 2;

   typedef enum logic [1:0] {
      MODE_CMD   = 2'd0,
      MODE_DATA  = 2'd1,
      MODE_REPLY = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_SECTOR = 3'd2,
      OP_CHIP   = 3'd3,
      OP_JEDEC  = 3'd4,
      OP_DEVID  = 3'd5,
      OP_PDOWN  = 3'd6,
      OP_WAKE   = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ACT_SEND    = 3'd0,
      ACT_RELEASE = 3'd1,
      ACT_READ    = 3'd2,
      ACT_ID      = 3'd3,
      ACT_DONE    = 3'd4,
      ACT_NEED    = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_WE_REPLY,
      PH_STAT_CMD,
      PH_STAT_POLL,
      PH_CMD_REPLY,
      PH_ADDR_REPLY,
      PH_DATA_NEED,
      PH_DATA_REPLY,
      PH_RD_REPLY,
      PH_ID_REPLY,
      PH_SIMPLE_REPLY
   } phase_type;

   localparam logic [7:0] CMD_WREN   = 8'h06;
   localparam logic [7:0] CMD_RDSR   = 8'h05;
   localparam logic [7:0] CMD_READ   = 8'h03;
   localparam logic [7:0] CMD_PP     = 8'h02;
   localparam logic [7:0] CMD_SE     = 8'h20;
   localparam logic [7:0] CMD_CE     = 8'hC7;
   localparam logic [7:0] CMD_JEDEC  = 8'h9F;
   localparam logic [7:0] CMD_RES    = 8'hAB;
   localparam logic [7:0] CMD_PD     = 8'hB9;
   localparam logic [7:0] CMD_DUMMY  = 8'hFF;

   // Classified input beat, as held in the queue.
   typedef struct packed {
      mode_type    mode;
      op_type      op;
      logic [23:0] address;
      logic [15:0] length;
      logic [7:0]  bval;
   } entry_type;

   // One result beat.
   typedef struct packed {
      action_type  action;
      logic [7:0]  tx_byte;
      logic [23:0] value;
      logic        last;
   } result_type;

endpackage
`default_nettype wire

/* sv/snfcs_if.sv */
// ----------------------------------------------------------------------------
// Sequencer channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none
interface snfcs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [2:0]  op;
   logic [23:0] address;
   logic [15:0] length;
   logic [7:0]  data_byte;
   logic [7:0]  rx_byte;
   modport source (output valid, mode, op, address, length, data_byte, rx_byte,
                   input ready);
   modport sink   (input valid, mode, op, address, length, data_byte, rx_byte,
                   output ready);
endinterface

interface snfcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  tx_byte;
   logic [23:0] value;
   logic        last;
   modport source (output valid, action, tx_byte, value, last, input ready);
   modport sink   (input valid, action, tx_byte, value, last, output ready);
endinterface
`default_nettype wire

/* sv/spi_nor_flash_command_sequencer_core.sv */
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer core
// Byte-level command framing, status polling and page splitting for a
// 24-bit address serial NOR flash.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat content
// req      in   mode, op, address, length, data_byte, rx_byte
// rsp      out  action, tx_byte, value, last
//
// A request beat is taken every cycle while the two-entry queue has room.
// The back end emits one result per cycle while the skid pair has room;
// an entry makes one to three results, and one with none is just popped.
// Reset is synchronous and returns the sequencer to idle.
// Either side may stall; the queue and the output skid pair absorb it.
// ----------------------------------------------------------------------------
`default_nettype none
module spi_nor_flash_command_sequencer_core #(
   parameter int unsigned PAGE_SIZE = snfcs_pkg::PAGE_SIZE_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   snfcs_req_if.sink   req,
   snfcs_rsp_if.source rsp
);
   snfcs_pkg::entry_type  in_entry, q_entry;
   snfcs_pkg::result_type out_result;
   logic q_valid, q_pop;

   // Data and reply share one byte slot in the queue.
   always_comb begin
      in_entry.mode    = snfcs_pkg::mode_type'(req.mode);
      in_entry.op      = snfcs_pkg::op_type'(req.op);
      in_entry.address = req.address;
      in_entry.length  = req.length;
      in_entry.bval    = (req.mode == snfcs_pkg::MODE_DATA) ? req.data_byte : req.rx_byte;
   end

   snfcs_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_entry,
      .q_valid, .q_pop, .q_entry
   );

   snfcs_back #(.PAGE_SIZE(PAGE_SIZE)) u_back (
      .clock, .reset,
      .q_valid, .q_pop, .q_entry,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_result
   );

   assign rsp.action  = out_result.action;
   assign rsp.tx_byte = out_result.tx_byte;
   assign rsp.value   = out_result.value;
   assign rsp.last    = out_result.last;
endmodule
`default_nettype wire

/* sv/snfcs_front.sv */
// ----------------------------------------------------------------------------
// Sequencer front end
// Accepts request beats, drops mode 3 and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none
module snfcs_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire snfcs_pkg::entry_type in_entry,
   output logic                      q_valid,
   input  wire logic                 q_pop,
   output snfcs_pkg::entry_type      q_entry
);
   localparam int unsigned AW = $clog2(snfcs_pkg::QUEUE_DEPTH);

   snfcs_pkg::entry_type mem_ff [snfcs_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push;

   // Mode 3 beats are taken and dropped here.
   assign in_ready = (cnt_ff != AW'(0) + (AW+1)'(snfcs_pkg::QUEUE_DEPTH)) || q_pop;
   assign push     = in_valid && in_ready && (in_entry.mode != snfcs_pkg::MODE_NONE);
   assign q_valid  = cnt_ff != '0;
   assign q_entry  = mem_ff[rd_ff];

   // Pointer and count update.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(snfcs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_in = (rd_ff == AW'(snfcs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_entry;
      end
   end
endmodule
`default_nettype wire

/* sv/snfcs_back.sv */
// ----------------------------------------------------------------------------
// Sequencer back end
// Executes queued beats, producing up to three result beats per entry,
// one per cycle while the two-entry output skid buffer has room.
// ----------------------------------------------------------------------------
`default_nettype none
module snfcs_back #(
   parameter int unsigned PAGE_SIZE = snfcs_pkg::PAGE_SIZE_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   output logic                      q_pop,
   input  wire snfcs_pkg::entry_type q_entry,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output snfcs_pkg::result_type     out_result
);
   localparam int unsigned PB = $clog2(PAGE_SIZE);
   localparam int unsigned CW = PB + 1;

   snfcs_pkg::phase_type phase_ff, phase_in;
   snfcs_pkg::op_type    op_ff, op_in;
   logic [23:0] addr_ff, addr_in;
   logic [15:0] left_ff, left_in;
   logic [CW-1:0] chunk_ff, chunk_in;
   logic [2:0]  fc_ff, fc_in;
   logic [23:0] id_ff, id_in;
   logic        aw_ff, aw_in;

   // Result list built for the entry at the queue head.
   snfcs_pkg::result_type res [4];
   logic [2:0] nres;
   logic [1:0] idx_ff, idx_in;

   // Output skid pair.
   snfcs_pkg::result_type ob_ff [2];
   logic [1:0] ocnt_ff, ocnt_in;
   logic       emit_one;
   snfcs_pkg::result_type cur;

   logic [PB:0]   room;
   logic [CW-1:0] chunk_calc;
   logic [7:0]    sh_byte;
   logic [2:0]    total;
   logic [23:0]   id_new;

   // Chunk size: remaining room in the page, capped by bytes left.
   always_comb begin
      room = (PB+1)'(PAGE_SIZE) - {1'b0, addr_in_base()[PB-1:0]};
      chunk_calc = ({{(16 > CW ? 0 : CW-16){1'b0}}, left_base()} < 16'(room))
                 ? CW'(left_base()) : CW'(room);
   end

   function automatic logic [23:0] addr_in_base();
      return (q_entry.mode == snfcs_pkg::MODE_CMD && phase_ff == snfcs_pkg::PH_IDLE)
             ? q_entry.address : addr_ff;
   endfunction
   function automatic logic [15:0] left_base();
      return (q_entry.mode == snfcs_pkg::MODE_CMD && phase_ff == snfcs_pkg::PH_IDLE)
             ? q_entry.length : left_ff;
   endfunction

   // Address byte selected by frame count.
   always_comb begin
      case (fc_ff)
         3'd0:    sh_byte = addr_ff[23:16];
         3'd1:    sh_byte = addr_ff[15:8];
         default: sh_byte = addr_ff[7:0];
      endcase
   end

   function automatic snfcs_pkg::result_type mk(snfcs_pkg::action_type a,
                                                 logic [7:0] t, logic [23:0] v);
      snfcs_pkg::result_type r;
      r.action = a; r.tx_byte = t; r.value = v; r.last = 1'b0;
      return r;
   endfunction

   // Sequencer step for the head entry.
   always_comb begin
      phase_in = phase_ff; op_in = op_ff; addr_in = addr_ff; left_in = left_ff;
      chunk_in = chunk_ff; fc_in = fc_ff; id_in = id_ff; aw_in = aw_ff;
      for (int i = 0; i < 4; i++) res[i] = mk(snfcs_pkg::ACT_SEND, 8'h00, 24'h0);
      nres = 3'd0;
      total = (op_ff == snfcs_pkg::OP_JEDEC) ? 3'd3 : 3'd4;
      id_new = (fc_ff != 3'd0) ? {id_ff[15:0], q_entry.bval} : id_ff;
      case (q_entry.mode)
         snfcs_pkg::MODE_CMD: begin
            if (phase_ff == snfcs_pkg::PH_IDLE) begin
               op_in   = snfcs_pkg::op_type'(q_entry.op);
               addr_in = q_entry.address;
               left_in = q_entry.length;
               case (snfcs_pkg::op_type'(q_entry.op))
                  snfcs_pkg::OP_WRITE: begin
                     if (q_entry.length == 16'd0) begin
                        res[0] = mk(snfcs_pkg::ACT_DONE, 8'h00, 24'h0); nres = 3'd1;
                     end else begin
                        chunk_in = chunk_calc;
                        res[0] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_WREN, 24'h0);
                        nres = 3'd1; phase_in = snfcs_pkg::PH_WE_REPLY;
                     end
                  end
                  snfcs_pkg::OP_SECTOR, snfcs_pkg::OP_CHIP: begin
                     res[0] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_WREN, 24'h0);
                     nres = 3'd1; phase_in = snfcs_pkg::PH_WE_REPLY;
                  end
                  snfcs_pkg::OP_PDOWN: begin
                     res[0] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_PD, 24'h0);
                     nres = 3'd1; phase_in = snfcs_pkg::PH_SIMPLE_REPLY;
                  end
                  snfcs_pkg::OP_WAKE: begin
                     res[0] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_RES, 24'h0);
                     nres = 3'd1; phase_in = snfcs_pkg::PH_SIMPLE_REPLY;
                  end
                  default: begin
                     aw_in = 1'b0;
                     res[0] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_RDSR, 24'h0);
                     nres = 3'd1; phase_in = snfcs_pkg::PH_STAT_CMD;
                  end
               endcase
            end
         end
         snfcs_pkg::MODE_DATA: begin
            if (phase_ff == snfcs_pkg::PH_DATA_NEED) begin
               res[0] = mk(snfcs_pkg::ACT_SEND, q_entry.bval, 24'h0); nres = 3'd1;
               if (chunk_ff != '0) chunk_in = chunk_ff - 1'b1;
               if (left_ff != '0) left_in = left_ff - 1'b1;
               addr_in = addr_ff + 24'd1;
               phase_in = snfcs_pkg::PH_DATA_REPLY;
            end
         end
         snfcs_pkg::MODE_REPLY: begin
            case (phase_ff)
               snfcs_pkg::PH_WE_REPLY: begin
                  res[0] = mk(snfcs_pkg::ACT_RELEASE, 8'h00, 24'h0);
                  res[1] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_RDSR, 24'h0);
                  nres = 3'd2; aw_in = 1'b0; phase_in = snfcs_pkg::PH_STAT_CMD;
               end
               snfcs_pkg::PH_STAT_CMD: begin
                  res[0] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_DUMMY, 24'h0);
                  nres = 3'd1; phase_in = snfcs_pkg::PH_STAT_POLL;
               end
               snfcs_pkg::PH_STAT_POLL: begin
                  if (q_entry.bval[0]) begin
                     res[0] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_DUMMY, 24'h0);
                     nres = 3'd1;
                  end else begin
                     res[0] = mk(snfcs_pkg::ACT_RELEASE, 8'h00, 24'h0);
                     nres = 3'd2;
                     if (!aw_ff) begin
                        fc_in = 3'd0;
                        case (op_ff)
                           snfcs_pkg::OP_READ: begin
                              res[1] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_READ, 24'h0);
                              phase_in = snfcs_pkg::PH_CMD_REPLY;
                           end
                           snfcs_pkg::OP_WRITE: begin
                              res[1] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_PP, 24'h0);
                              phase_in = snfcs_pkg::PH_CMD_REPLY;
                           end
                           snfcs_pkg::OP_SECTOR: begin
                              res[1] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_SE, 24'h0);
                              phase_in = snfcs_pkg::PH_CMD_REPLY;
                           end
                           snfcs_pkg::OP_CHIP: begin
                              res[1] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_CE, 24'h0);
                              phase_in = snfcs_pkg::PH_SIMPLE_REPLY;
                           end
                           snfcs_pkg::OP_JEDEC: begin
                              id_in = '0;
                              res[1] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_JEDEC, 24'h0);
                              phase_in = snfcs_pkg::PH_ID_REPLY;
                           end
                           default: begin
                              id_in = '0;
                              res[1] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_RES, 24'h0);
                              phase_in = snfcs_pkg::PH_ID_REPLY;
                           end
                        endcase
                     end else if (op_ff == snfcs_pkg::OP_WRITE && left_ff != '0) begin
                        chunk_in = chunk_calc;
                        res[1] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_WREN, 24'h0);
                        phase_in = snfcs_pkg::PH_WE_REPLY;
                     end else begin
                        res[1] = mk(snfcs_pkg::ACT_DONE, 8'h00, 24'h0);
                        phase_in = snfcs_pkg::PH_IDLE;
                     end
                  end
               end
               snfcs_pkg::PH_CMD_REPLY: begin
                  res[0] = mk(snfcs_pkg::ACT_SEND, addr_ff[23:16], 24'h0);
                  nres = 3'd1; fc_in = 3'd1; phase_in = snfcs_pkg::PH_ADDR_REPLY;
               end
               snfcs_pkg::PH_ADDR_REPLY: begin
                  if (fc_ff < 3'd3) begin
                     res[0] = mk(snfcs_pkg::ACT_SEND, sh_byte, 24'h0);
                     nres = 3'd1; fc_in = fc_ff + 3'd1;
                  end else if (op_ff == snfcs_pkg::OP_READ) begin
                     if (left_ff != '0) begin
                        res[0] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_DUMMY, 24'h0);
                        nres = 3'd1; phase_in = snfcs_pkg::PH_RD_REPLY;
                     end else begin
                        res[0] = mk(snfcs_pkg::ACT_RELEASE, 8'h00, 24'h0);
                        res[1] = mk(snfcs_pkg::ACT_DONE, 8'h00, 24'h0);
                        nres = 3'd2; phase_in = snfcs_pkg::PH_IDLE;
                     end
                  end else if (op_ff == snfcs_pkg::OP_WRITE) begin
                     res[0] = mk(snfcs_pkg::ACT_NEED, 8'h00, 24'h0);
                     nres = 3'd1; phase_in = snfcs_pkg::PH_DATA_NEED;
                  end else begin
                     res[0] = mk(snfcs_pkg::ACT_RELEASE, 8'h00, 24'h0);
                     res[1] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_RDSR, 24'h0);
                     nres = 3'd2; aw_in = 1'b1; phase_in = snfcs_pkg::PH_STAT_CMD;
                  end
               end
               snfcs_pkg::PH_DATA_REPLY: begin
                  if (chunk_ff != '0) begin
                     res[0] = mk(snfcs_pkg::ACT_NEED, 8'h00, 24'h0);
                     nres = 3'd1; phase_in = snfcs_pkg::PH_DATA_NEED;
                  end else begin
                     res[0] = mk(snfcs_pkg::ACT_RELEASE, 8'h00, 24'h0);
                     res[1] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_RDSR, 24'h0);
                     nres = 3'd2; aw_in = 1'b1; phase_in = snfcs_pkg::PH_STAT_CMD;
                  end
               end
               snfcs_pkg::PH_RD_REPLY: begin
                  res[0] = mk(snfcs_pkg::ACT_READ, 8'h00, {16'h0, q_entry.bval});
                  addr_in = addr_ff + 24'd1;
                  left_in = (left_ff != '0) ? left_ff - 1'b1 : left_ff;
                  if (left_in != '0) begin
                     res[1] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_DUMMY, 24'h0);
                     nres = 3'd2;
                  end else begin
                     res[1] = mk(snfcs_pkg::ACT_RELEASE, 8'h00, 24'h0);
                     res[2] = mk(snfcs_pkg::ACT_DONE, 8'h00, 24'h0);
                     nres = 3'd3; phase_in = snfcs_pkg::PH_IDLE;
                  end
               end
               snfcs_pkg::PH_ID_REPLY: begin
                  id_in = id_new;
                  fc_in = fc_ff + 3'd1;
                  if (fc_in <= total) begin
                     res[0] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_DUMMY, 24'h0);
                     nres = 3'd1;
                  end else begin
                     res[0] = mk(snfcs_pkg::ACT_RELEASE, 8'h00, 24'h0);
                     res[1] = mk(snfcs_pkg::ACT_ID, 8'h00,
                                 (op_ff == snfcs_pkg::OP_JEDEC) ? id_new
                                                                : {16'h0, id_new[7:0]});
                     res[2] = mk(snfcs_pkg::ACT_DONE, 8'h00, 24'h0);
                     nres = 3'd3; phase_in = snfcs_pkg::PH_IDLE;
                  end
               end
               snfcs_pkg::PH_SIMPLE_REPLY: begin
                  res[0] = mk(snfcs_pkg::ACT_RELEASE, 8'h00, 24'h0);
                  nres = 3'd2;
                  if (op_ff == snfcs_pkg::OP_CHIP) begin
                     res[1] = mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_RDSR, 24'h0);
                     aw_in = 1'b1; phase_in = snfcs_pkg::PH_STAT_CMD;
                  end else begin
                     res[1] = mk(snfcs_pkg::ACT_DONE, 8'h00, 24'h0);
                     phase_in = snfcs_pkg::PH_IDLE;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Emit one result per cycle while the skid pair has room.
   always_comb begin
      cur = res[idx_ff];
      cur.last = ({1'b0, idx_ff} + 3'd1 == nres);
      emit_one = q_valid && (nres != 3'd0) && (ocnt_ff != 2'd2 || out_ready);
      q_pop = q_valid && ((nres == 3'd0) || (emit_one && cur.last));
      idx_in = idx_ff;
      if (emit_one) idx_in = cur.last ? 2'd0 : idx_ff + 2'd1;
      ocnt_in = ocnt_ff + {1'b0, emit_one} - {1'b0, out_valid && out_ready};
   end

   assign out_valid  = ocnt_ff != 2'd0;
   assign out_result = ob_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= snfcs_pkg::PH_IDLE;
         op_ff    <= snfcs_pkg::OP_READ;
         addr_ff  <= '0;
         left_ff  <= '0;
         chunk_ff <= '0;
         fc_ff    <= '0;
         id_ff    <= '0;
         aw_ff    <= 1'b0;
         idx_ff   <= '0;
         ocnt_ff  <= '0;
      end else begin
         if (q_pop) begin
            phase_ff <= phase_in;
            op_ff    <= op_in;
            addr_ff  <= addr_in;
            left_ff  <= left_in;
            chunk_ff <= chunk_in;
            fc_ff    <= fc_in;
            id_ff    <= id_in;
            aw_ff    <= aw_in;
         end
         idx_ff  <= idx_in;
         ocnt_ff <= ocnt_in;
      end
   end

   // Skid pair data movement.
   always_ff @(posedge clock) begin
      if (out_valid && out_ready) begin
         ob_ff[0] <= (ocnt_ff == 2'd2) ? ob_ff[1] : cur;
         if (ocnt_ff == 2'd2) ob_ff[1] <= cur;
      end else if (emit_one) begin
         if (ocnt_ff == 2'd0) ob_ff[0] <= cur;
         else ob_ff[1] <= cur;
      end
   end
endmodule
`default_nettype wire

/* sv/snfcs_checker.sv */
// ----------------------------------------------------------------------------
// Sequencer port checker
// Watches the top-level ports for handshake and result encoding rules.
// ----------------------------------------------------------------------------
`default_nettype none
module snfcs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_action,
   input wire logic [7:0]  rsp_tx_byte,
   input wire logic [23:0] rsp_value
);
   // A stalled result beat stays valid with its action unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action))
      else $error("result beat changed under stall");

   // No result beats right after reset.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // Only send beats carry a transmit byte.
   a_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != 3'd0 |-> rsp_tx_byte == 8'h00)
      else $error("transmit byte on a non-send beat");

   // Only read and id beats carry a value.
   a_val: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != 3'd2 && rsp_action != 3'd3 |-> rsp_value == 24'h0)
      else $error("value on a non-data beat");
endmodule

bind spi_nor_flash_command_sequencer_core snfcs_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_action(rsp.action), .rsp_tx_byte(rsp.tx_byte), .rsp_value(rsp.value)
);
`default_nettype wire

/* test/snfcs_flash_checker.sv */
// ----------------------------------------------------------------------------
// SPI NOR flash sequencer checker
// Watches the request and result channels, predicts the result beats of
// every accepted request beat and compares them in order, field by field.
// ----------------------------------------------------------------------------
module snfcs_flash_checker
   import snfcs_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   snfcs_req_if  req,
   snfcs_rsp_if  rsp,
   output int    mismatches,
   output int    beats_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   // Predicted sequencer state.
   phase_type   seq_phase;
   op_type      cur_op;
   logic [23:0] flash_addr;
   logic [15:0] bytes_left;
   logic [8:0]  page_left;
   int          frames;
   logic [23:0] id_acc;
   logic        poll_then_finish;

   result_type  expected_beats[$];
   result_type  item_beats[$];

   function automatic void put(action_type a, logic [7:0] tx, logic [23:0] v);
      result_type r;
      r.action  = a;
      r.tx_byte = tx;
      r.value   = v;
      r.last    = 1'b0;
      if (item_beats.size() < 4) item_beats.push_back(r);
   endfunction

   function automatic void send_byte(logic [7:0] b);
      put(ACT_SEND, b, 24'd0);
   endfunction

   function automatic void finish_op();
      put(ACT_DONE, 8'd0, 24'd0);
      seq_phase = PH_IDLE;
   endfunction

   function automatic void start_poll(logic then_finish);
      poll_then_finish = then_finish;
      send_byte(CMD_RDSR);
      seq_phase = PH_STAT_CMD;
   endfunction

   // A page program never runs past the end of the current page.
   function automatic void start_page();
      int room;
      room = PAGE_SIZE_DEFAULT - (flash_addr % PAGE_SIZE_DEFAULT);
      page_left = (bytes_left < room) ? bytes_left : room;
      send_byte(CMD_WREN);
      seq_phase = PH_WE_REPLY;
   endfunction

   function automatic void start_frame();
      frames = 0;
      case (cur_op)
         OP_READ: begin send_byte(CMD_READ); seq_phase = PH_CMD_REPLY; end
         OP_WRITE: begin send_byte(CMD_PP); seq_phase = PH_CMD_REPLY; end
         OP_SECTOR: begin send_byte(CMD_SE); seq_phase = PH_CMD_REPLY; end
         OP_CHIP: begin send_byte(CMD_CE); seq_phase = PH_SIMPLE_REPLY; end
         OP_JEDEC: begin
            id_acc = '0;
            send_byte(CMD_JEDEC);
            seq_phase = PH_ID_REPLY;
         end
         default: begin
            id_acc = '0;
            send_byte(CMD_RES);
            seq_phase = PH_ID_REPLY;
         end
      endcase
   endfunction

   function automatic void wrap_up();
      if (cur_op == OP_WRITE && bytes_left > 0) start_page();
      else finish_op();
   endfunction

   function automatic void send_addr();
      send_byte(8'(flash_addr >> (8 * (2 - frames))));
      frames++;
      seq_phase = PH_ADDR_REPLY;
   endfunction

   function automatic void take_reply(logic [7:0] rx);
      int total;
      case (seq_phase)
         PH_WE_REPLY: begin
            put(ACT_RELEASE, 8'd0, 24'd0);
            start_poll(1'b0);
         end
         PH_STAT_CMD: begin
            send_byte(CMD_DUMMY);
            seq_phase = PH_STAT_POLL;
         end
         PH_STAT_POLL: begin
            // Keep polling while the write-in-progress bit is set.
            if (rx[0]) send_byte(CMD_DUMMY);
            else begin
               put(ACT_RELEASE, 8'd0, 24'd0);
               if (!poll_then_finish) start_frame();
               else wrap_up();
            end
         end
         PH_CMD_REPLY: begin
            frames = 0;
            send_addr();
         end
         PH_ADDR_REPLY: begin
            if (frames < 3) send_addr();
            else if (cur_op == OP_READ) begin
               if (bytes_left > 0) begin
                  send_byte(CMD_DUMMY);
                  seq_phase = PH_RD_REPLY;
               end else begin
                  put(ACT_RELEASE, 8'd0, 24'd0);
                  finish_op();
               end
            end else if (cur_op == OP_WRITE) begin
               put(ACT_NEED, 8'd0, 24'd0);
               seq_phase = PH_DATA_NEED;
            end else begin
               put(ACT_RELEASE, 8'd0, 24'd0);
               start_poll(1'b1);
            end
         end
         PH_DATA_REPLY: begin
            if (page_left > 0) begin
               put(ACT_NEED, 8'd0, 24'd0);
               seq_phase = PH_DATA_NEED;
            end else begin
               put(ACT_RELEASE, 8'd0, 24'd0);
               start_poll(1'b1);
            end
         end
         PH_RD_REPLY: begin
            put(ACT_READ, 8'd0, {16'd0, rx});
            if (bytes_left > 0) bytes_left--;
            flash_addr = flash_addr + 24'd1;
            if (bytes_left > 0) send_byte(CMD_DUMMY);
            else begin
               put(ACT_RELEASE, 8'd0, 24'd0);
               finish_op();
            end
         end
         PH_ID_REPLY: begin
            total = (cur_op == OP_JEDEC) ? 3 : 4;
            // The reply to the opcode itself carries no identifier bits.
            if (frames > 0) id_acc = {id_acc[15:0], rx};
            frames++;
            if (frames <= total) send_byte(CMD_DUMMY);
            else begin
               put(ACT_RELEASE, 8'd0, 24'd0);
               put(ACT_ID, 8'd0, (cur_op == OP_JEDEC) ? id_acc : {16'd0, id_acc[7:0]});
               finish_op();
            end
         end
         PH_SIMPLE_REPLY: begin
            put(ACT_RELEASE, 8'd0, 24'd0);
            if (cur_op == OP_CHIP) start_poll(1'b1);
            else finish_op();
         end
         default: ;
      endcase
   endfunction

   // Works out the result beats of one request beat and queues them.
   function automatic void predict_flash_beat(mode_type m, op_type o, logic [23:0] a,
                                              logic [15:0] n, logic [7:0] d,
                                              logic [7:0] rx);
      item_beats.delete();
      case (m)
         MODE_CMD: begin
            if (seq_phase == PH_IDLE) begin
               cur_op     = o;
               flash_addr = a;
               bytes_left = n;
               case (o)
                  OP_WRITE: begin
                     if (n == 0) finish_op();
                     else start_page();
                  end
                  OP_SECTOR, OP_CHIP: begin
                     send_byte(CMD_WREN);
                     seq_phase = PH_WE_REPLY;
                  end
                  OP_PDOWN: begin
                     send_byte(CMD_PD);
                     seq_phase = PH_SIMPLE_REPLY;
                  end
                  OP_WAKE: begin
                     send_byte(CMD_RES);
                     seq_phase = PH_SIMPLE_REPLY;
                  end
                  default: start_poll(1'b0);
               endcase
            end
         end
         MODE_DATA: begin
            if (seq_phase == PH_DATA_NEED) begin
               send_byte(d);
               if (page_left > 0) page_left--;
               if (bytes_left > 0) bytes_left--;
               flash_addr = flash_addr + 24'd1;
               seq_phase = PH_DATA_REPLY;
            end
         end
         MODE_REPLY: take_reply(rx);
         default: ;
      endcase
      if (item_beats.size() > 0) item_beats[item_beats.size() - 1].last = 1'b1;
      foreach (item_beats[i]) expected_beats.push_back(item_beats[i]);
   endfunction

   // Predict on every accepted request beat, then check every result beat.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         seq_phase        = PH_IDLE;
         cur_op           = OP_READ;
         flash_addr       = '0;
         bytes_left       = '0;
         page_left        = '0;
         frames           = 0;
         id_acc           = '0;
         poll_then_finish = 1'b0;
         expected_beats.delete();
      end else begin
         if (req.valid && req.ready)
            predict_flash_beat(mode_type'(req.mode), op_type'(req.op), req.address,
                               req.length, req.data_byte, req.rx_byte);
         if (rsp.valid && rsp.ready) begin
            if (expected_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result beat action=%0d tx=%02h value=%06h last=%0b",
                           $realtime, rsp.action, rsp.tx_byte, rsp.value, rsp.last);
            end else begin
               want = expected_beats.pop_front();
               if (rsp.action !== want.action || rsp.tx_byte !== want.tx_byte ||
                   rsp.value !== want.value || rsp.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch expected action=%0d tx=%02h value=%06h last=%0b, got action=%0d tx=%02h value=%06h last=%0b",
                              $realtime, want.action, want.tx_byte, want.value, want.last,
                              rsp.action, rsp.tx_byte, rsp.value, rsp.last);
               end
            end
         end
      end
      beats_owed = expected_beats.size();
   end

   initial begin
      mismatches = 0;
      beats_owed = 0;
   end

endmodule

/* test/spi_nor_flash_command_sequencer_core_tb.sv */
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer testbench
// Plays the host and the flash device: it issues flash operations, answers
// every sent byte with a reply beat and every data request with a data beat,
// mixes in beats that the sequencer must ignore, and stalls both channels.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_core_tb;
   import snfcs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   int   mismatches;
   int   beats_owed;

   snfcs_req_if req ();
   snfcs_rsp_if rsp ();

   spi_nor_flash_command_sequencer_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   snfcs_flash_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .mismatches (mismatches),
      .beats_owed (beats_owed)
   );

   // Bookkeeping of what the sequencer has asked of the host and the flash.
   int   sends_seen;
   int   needs_seen;
   int   dones_seen;
   int   replies_given;
   int   data_given;
   int   ops_started;
   int   items_sent;
   logic idle_on;
   logic hold_req;
   logic holding;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (rsp.action == ACT_SEND) sends_seen <= sends_seen + 1;
         if (rsp.action == ACT_NEED) needs_seen <= needs_seen + 1;
         if (rsp.action == ACT_DONE) dones_seen <= dones_seen + 1;
      end
   end

   // Offers one request beat and waits until it is taken.
   task automatic offer(mode_type m, op_type o, logic [23:0] a, logic [15:0] n,
                        logic [7:0] d, logic [7:0] rx);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.mode      <= m;
      req.op        <= o;
      req.address   <= a;
      req.length    <= n;
      req.data_byte <= d;
      req.rx_byte   <= rx;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // A beat the sequencer must ignore in its current wait state.
   task automatic offer_stray(mode_type wrong);
      if ($urandom_range(0, 1)) offer(MODE_NONE, op_type'($urandom_range(0, 7)), $urandom,
                                      $urandom, $urandom, $urandom);
      else offer(wrong, op_type'($urandom_range(0, 7)), $urandom, $urandom,
                 $urandom, $urandom);
   endtask

   // Answers the sequencer until the current operation reports done.
   task automatic serve_flash();
      while (ops_started != dones_seen) begin
         idle_on = (items_sent % 80) < 50;
         if (items_sent >= 100) hold_req = 1'b1;
         if (sends_seen != replies_given) begin
            // Waiting for a reply: a data or command beat is ignored.
            if ($urandom_range(0, 9) == 0)
               offer_stray($urandom_range(0, 1) ? MODE_DATA : MODE_CMD);
            else begin
               offer(MODE_REPLY, OP_READ, $urandom, $urandom, $urandom,
                     $urandom_range(0, 255));
               replies_given++;
               items_sent++;
            end
         end else if (needs_seen != data_given) begin
            // Waiting for write data: a reply or command beat is ignored.
            if ($urandom_range(0, 9) == 0)
               offer_stray($urandom_range(0, 1) ? MODE_REPLY : MODE_CMD);
            else begin
               offer(MODE_DATA, OP_READ, $urandom, $urandom, $urandom_range(0, 255),
                     $urandom);
               data_given++;
               items_sent++;
            end
         end else if (holding) begin
            // Keep the input busy during the long stall; mode 3 beats are dropped, not queued.
            offer(MODE_NONE, OP_READ, $urandom, $urandom, $urandom, $urandom);
         end else begin
            req.valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   task automatic run_op(op_type o, logic [23:0] a, logic [15:0] n);
      offer(MODE_CMD, o, a, n, $urandom, $urandom);
      ops_started++;
      items_sent++;
      serve_flash();
   endtask

   // Random operation; transfer lengths stay short so pages still get crossed.
   task automatic run_random_op();
      op_type      o;
      logic [23:0] a;
      logic [15:0] n;
      o = op_type'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
         0: a = $urandom;
         1: a = {$urandom_range(0, 16'hFFFF), 8'(8'hF8 + $urandom_range(0, 7))};
         2: a = 24'hFFFFFF - $urandom_range(0, 3);
         default: a = $urandom_range(0, 600);
      endcase
      if (o == OP_READ || o == OP_WRITE)
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
      else n = $urandom;
      run_op(o, a, n);
   endtask

   // Result side: random stalls per beat, plus long hold-offs after the first hundred items.
   initial begin
      rsp.ready = 1'b0;
      holding   = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         int stall;
         stall = idle_on ? $urandom_range(0, 3) : 0;
         if (hold_req && !holding) begin
            hold_req = 1'b0;
            holding  = 1'b1;
            rsp.ready <= 1'b0;
            repeat (80) @(posedge clock);
            holding  = 1'b0;
         end else if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      logic hold_used;
      reset         = 1'b1;
      req.valid     = 1'b0;
      req.mode      = MODE_NONE;
      req.op        = OP_READ;
      req.address   = '0;
      req.length    = '0;
      req.data_byte = '0;
      req.rx_byte   = '0;
      sends_seen    = 0;
      needs_seen    = 0;
      dones_seen    = 0;
      replies_given = 0;
      data_given    = 0;
      ops_started   = 0;
      items_sent    = 0;
      idle_on       = 1'b1;
      hold_req      = 1'b0;
      hold_used     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed operations: every op, empty transfers, page crossing and wrap.
      run_op(OP_READ, 24'hFFFFFF, 16'd2);
      run_op(OP_READ, 24'h000000, 16'd0);
      run_op(OP_WRITE, 24'h0000FE, 16'd4);
      run_op(OP_WRITE, 24'h123456, 16'd0);
      run_op(OP_WRITE, 24'hFFFFFF, 16'd2);
      run_op(OP_SECTOR, 24'hABCDEF, 16'hFFFF);
      run_op(OP_CHIP, 24'h000000, 16'h0000);
      run_op(OP_JEDEC, 24'h5A5A5A, 16'hA5A5);
      run_op(OP_DEVID, 24'hA5A5A5, 16'h5A5A);
      run_op(OP_PDOWN, 24'hFFFFFF, 16'hFFFF);
      run_op(OP_WAKE, 24'h000000, 16'h0000);

      while (items_sent < 200) run_random_op();
      req.valid <= 1'b0;

      while (beats_owed != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
